>>> rtl/lflc_pkg.sv
// ----------------------------------------------------------------------------
// lflc_pkg: shared types and constants
// Request and result payloads, operation, direction and side codes, register indexes and
// register reset values for the line-follow lane-change controller.
// ----------------------------------------------------------------------------
package lflc_pkg;

    // operation codes of a command request
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // drive directions
    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    // side being avoided
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_NEAR_LIMIT    = 3'd0;
    localparam logic [2:0] CFG_CLEAR_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_CONFIRM_COUNT = 3'd2;
    localparam logic [2:0] CFG_SINGLE_TICKS  = 3'd3;
    localparam logic [2:0] CFG_REJOIN_TICKS  = 3'd4;
    localparam logic [2:0] CFG_CRUISE_SPEED  = 3'd5;
    localparam logic [2:0] CFG_TURN_SPEED    = 3'd6;

    // register reset values
    localparam logic [15:0] NEAR_LIMIT_RST    = 16'd150;
    localparam logic [15:0] CLEAR_LIMIT_RST   = 16'd400;
    localparam logic [3:0]  CONFIRM_COUNT_RST = 4'd3;
    localparam logic [9:0]  SINGLE_TICKS_RST  = 10'd300;
    localparam logic [9:0]  REJOIN_TICKS_RST  = 10'd75;
    localparam logic [9:0]  CRUISE_SPEED_RST  = 10'd600;
    localparam logic [9:0]  TURN_SPEED_RST    = 10'd400;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  line_bits;
        logic [15:0] left_distance;
        logic [15:0] right_distance;
    } cmd_item_t;

    typedef struct packed {
        logic       drive_valid;
        logic [1:0] drive_dir;
        logic [9:0] drive_speed;
        logic [2:0] mode_now;
    } res_item_t;

endpackage

>>> rtl/line_follow_lane_change_fsm.sv
// ----------------------------------------------------------------------------
// line_follow_lane_change_fsm: line-following controller with lane change
// Issues one drive command per tick from the current mode and line sensors, then advances
// the mode on obstacle confirm, clearance, line pickup and tick timeouts; start/stop set it.
// ----------------------------------------------------------------------------
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  cmd     | cmd_valid, cmd_stall, cmd_item       | in
//  res     | res_valid, res_stall, res_item       | out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | in
//
// Each request gives exactly one result: an accepted request is held in the
// input register, the mode logic works on it and loads the result register
// once the result side is free. A new request is taken every cycle while
// cmd_stall is low. cmd_stall rises only when both the input and result
// registers are full and res_stall is high. Reset clears mode, avoided side
// and count, and loads the register defaults. cfg_ready is always high.
module line_follow_lane_change_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  lflc_pkg::cmd_item_t cmd_item,
    output logic                res_valid,
    input  logic                res_stall,
    output lflc_pkg::res_item_t res_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import lflc_pkg::*;

    typedef enum logic [2:0] {
        MODE_DOUBLE   = 3'd0,
        MODE_SINGLE   = 3'd1,
        MODE_IN_TURN  = 3'd2,
        MODE_IN_FWD   = 3'd3,
        MODE_OUT_TURN = 3'd4,
        MODE_OUT_FWD  = 3'd5,
        MODE_STOP     = 3'd6
    } mode_t;

    // configuration
    logic [15:0] near_limit_reg;
    logic [15:0] clear_limit_reg;
    logic [3:0]  confirm_count_reg;
    logic [9:0]  single_ticks_reg;
    logic [9:0]  rejoin_ticks_reg;
    logic [9:0]  cruise_speed_reg;
    logic [9:0]  turn_speed_reg;

    // pipeline and state
    logic       item_valid_reg;
    cmd_item_t  item_reg;
    logic       res_valid_reg;
    res_item_t  res_item_reg;
    mode_t      mode_reg, mode_next;
    logic [1:0] side_reg, side_next;
    logic [9:0] tick_reg, tick_next;
    res_item_t  res_next;

    logic       res_free;
    logic       take;
    logic       left_near, right_near;
    logic       left_clear, right_clear;
    logic       s1, s2, s3, s4;
    logic [9:0] tick_inc;

    assign cfg_ready = 1'b1;
    assign res_free  = !res_valid_reg || !res_stall;
    assign take      = item_valid_reg && res_free;
    assign cmd_stall = item_valid_reg && !res_free;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_limit_reg    <= NEAR_LIMIT_RST;
            clear_limit_reg   <= CLEAR_LIMIT_RST;
            confirm_count_reg <= CONFIRM_COUNT_RST;
            single_ticks_reg  <= SINGLE_TICKS_RST;
            rejoin_ticks_reg  <= REJOIN_TICKS_RST;
            cruise_speed_reg  <= CRUISE_SPEED_RST;
            turn_speed_reg    <= TURN_SPEED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NEAR_LIMIT:    near_limit_reg    <= cfg_data;
                CFG_CLEAR_LIMIT:   clear_limit_reg   <= cfg_data;
                CFG_CONFIRM_COUNT: confirm_count_reg <= cfg_data[3:0];
                CFG_SINGLE_TICKS:  single_ticks_reg  <= cfg_data[9:0];
                CFG_REJOIN_TICKS:  rejoin_ticks_reg  <= cfg_data[9:0];
                CFG_CRUISE_SPEED:  cruise_speed_reg  <= cfg_data[9:0];
                CFG_TURN_SPEED:    turn_speed_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // input register: the request waits here while the result side is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            item_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            item_reg <= cmd_item;
        end
    end

    assign s1 = item_reg.line_bits[0];
    assign s2 = item_reg.line_bits[1];
    assign s3 = item_reg.line_bits[2];
    assign s4 = item_reg.line_bits[3];

    assign left_near   = item_reg.left_distance < near_limit_reg;
    assign right_near  = item_reg.right_distance < near_limit_reg;
    assign left_clear  = item_reg.left_distance > clear_limit_reg;
    assign right_clear = item_reg.right_distance > clear_limit_reg;
    assign tick_inc    = tick_reg + 10'd1;

    always_comb
    begin
        mode_next            = mode_reg;
        side_next            = side_reg;
        tick_next            = tick_reg;
        res_next.drive_valid = 1'b0;
        res_next.drive_dir   = DIR_FWD;
        res_next.drive_speed = '0;

        unique case (item_reg.op)
            OP_TICK:
            begin
                // drive command from the current mode
                unique case (mode_reg)
                    MODE_DOUBLE:
                    begin
                        if (!s4)
                        begin
                            res_next.drive_valid = 1'b1;
                            res_next.drive_dir   = s1 ? DIR_LEFT : DIR_FWD;
                            res_next.drive_speed = s1 ? turn_speed_reg : cruise_speed_reg;
                        end
                        else if (!s1)
                        begin
                            res_next.drive_valid = 1'b1;
                            res_next.drive_dir   = DIR_RIGHT;
                            res_next.drive_speed = turn_speed_reg;
                        end
                    end
                    MODE_SINGLE:
                    begin
                        if (!s3)
                        begin
                            res_next.drive_valid = 1'b1;
                            res_next.drive_dir   = s2 ? DIR_RIGHT : DIR_FWD;
                            res_next.drive_speed = s2 ? turn_speed_reg : cruise_speed_reg;
                        end
                        else if (!s2)
                        begin
                            res_next.drive_valid = 1'b1;
                            res_next.drive_dir   = DIR_LEFT;
                            res_next.drive_speed = turn_speed_reg;
                        end
                    end
                    MODE_IN_TURN, MODE_OUT_TURN:
                    begin
                        // change-in turns away from the avoided side, change-out toward it
                        if (side_reg == SIDE_LEFT || side_reg == SIDE_RIGHT)
                        begin
                            res_next.drive_valid = 1'b1;
                            res_next.drive_speed = turn_speed_reg;
                            if ((side_reg == SIDE_LEFT) == (mode_reg == MODE_IN_TURN))
                                res_next.drive_dir = DIR_RIGHT;
                            else
                                res_next.drive_dir = DIR_LEFT;
                        end
                    end
                    MODE_IN_FWD, MODE_OUT_FWD:
                    begin
                        res_next.drive_valid = 1'b1;
                        res_next.drive_speed = cruise_speed_reg;
                    end
                    MODE_STOP:
                    begin
                        res_next.drive_valid = 1'b1;
                    end
                    default: ;
                endcase

                // mode advance
                unique case (mode_reg)
                    MODE_DOUBLE:
                    begin
                        if (tick_reg == {6'd0, confirm_count_reg})
                        begin
                            tick_next = '0;
                            if (left_near)
                            begin
                                mode_next = MODE_IN_TURN;
                                side_next = SIDE_LEFT;
                            end
                            else if (right_near)
                            begin
                                mode_next = MODE_IN_TURN;
                                side_next = SIDE_RIGHT;
                            end
                        end
                        else if (left_near || right_near)
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    MODE_SINGLE:
                    begin
                        if (tick_inc > single_ticks_reg)
                        begin
                            mode_next = MODE_OUT_TURN;
                            tick_next = '0;
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    MODE_IN_TURN:
                    begin
                        if ((side_reg == SIDE_LEFT && left_clear) ||
                            (side_reg == SIDE_RIGHT && right_clear))
                            mode_next = MODE_IN_FWD;
                    end
                    MODE_IN_FWD:
                    begin
                        if ((side_reg == SIDE_LEFT && s2) || (side_reg == SIDE_RIGHT && s3))
                        begin
                            mode_next = MODE_SINGLE;
                            tick_next = '0;
                        end
                    end
                    MODE_OUT_TURN:
                    begin
                        if (tick_inc > rejoin_ticks_reg)
                        begin
                            mode_next = MODE_OUT_FWD;
                            tick_next = '0;
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    MODE_OUT_FWD:
                    begin
                        if ((side_reg == SIDE_LEFT && s4) || (side_reg == SIDE_RIGHT && s1))
                        begin
                            mode_next = MODE_DOUBLE;
                            tick_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
            OP_START: mode_next = MODE_DOUBLE;
            OP_STOP:  mode_next = MODE_STOP;
            default: ;
        endcase

        res_next.mode_now = mode_next;
    end

    // mode state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DOUBLE;
            side_reg      <= SIDE_NONE;
            tick_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg      <= mode_next;
            side_reg      <= side_next;
            tick_reg      <= tick_next;
            res_valid_reg <= 1'b1;
            res_item_reg  <= res_next;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    a_stop_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.drive_valid && res_item.mode_now == MODE_STOP
        && $past(take) |-> res_item.drive_speed == '0 || $past(mode_reg) != MODE_STOP)
        else $error("nonzero speed issued in stop mode");

    a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.drive_valid |->
        res_item.drive_dir == DIR_FWD && res_item.drive_speed == '0)
        else $error("idle command carries direction or speed");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> item_valid_reg && res_valid_reg && res_stall)
        else $error("input stalled while pipeline has room");

    a_start_mode: assert property (@(posedge clk) disable iff (!rst_n)
        take && item_reg.op == OP_START |=> mode_reg == MODE_DOUBLE)
        else $error("start request did not enter double line mode");

endmodule
